>>> src/bfe_pkg.sv
// Package for the edge-normalised 3x3 box filter.
// Holds default sizes, the controller state type and the command and status
// structs shared by the controller and the datapath. No dependencies.
package bfe_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 16;

   // Width of the row width register as it appears on the configuration port.
   localparam int CSR_BITS = 11;

   // Neighbour count is 1 to 9.
   localparam int CNT_BITS = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COLUMN,
      ST_SUM,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;     // item taken: write row store, read column, step counters
      logic shift;      // fold the new column into the window
      logic load;       // form the window sum and start the divider
      logic sel_last;   // current result is the one for the last column
      logic emit;       // load the output register
      logic frame_end;
      logic run_last;
   } cmd_type;

   typedef struct packed {
      logic gives_mid;  // item yields the result for the previous column
      logic gives_last; // item yields the result for the last column
      logic pad_item;   // item belongs to the padding row
      logic div_busy;
   } status_type;

endpackage

>>> src/bfe_if.sv
// Channel interfaces of the 3x3 box filter: pixel input, result output and
// the row width register write channel. Depends on bfe_pkg.
interface bfe_req_if import bfe_pkg::*; #(parameter int PIXEL_BITS = DEF_PIXEL_BITS) ();
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel;
   logic                         flush;

   modport source (output valid, output pixel, output flush, input ready);
   modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface bfe_rsp_if import bfe_pkg::*; #(parameter int PIXEL_BITS = DEF_PIXEL_BITS) ();
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] mean_value;
   logic                         frame_end;
   logic                         run_last;

   modport source (output valid, output mean_value, output frame_end, output run_last,
                   input ready);
   modport sink   (input valid, input mean_value, input frame_end, input run_last,
                   output ready);
endinterface

interface bfe_csr_if import bfe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CSR_BITS-1:0] row_width;

   modport source (output valid, output row_width, input ready);
   modport sink   (input valid, input row_width, output ready);
endinterface

>>> src/bfe_divider.sv
// Bit-serial signed divider for the box filter: window sum over neighbour count,
// truncating toward zero, one quotient bit per cycle. Depends on bfe_pkg.
module bfe_divider import bfe_pkg::*; #(
   parameter int WIN_BITS = DEF_PIXEL_BITS + 4,
   parameter int OUT_BITS = DEF_PIXEL_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [WIN_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0]        divisor,
   output logic                       busy,
   output logic signed [OUT_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(WIN_BITS);

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [WIN_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS-1:0]  den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [CNT_BITS:0]    trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[WIN_BITS-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         neg_in  = dividend[WIN_BITS-1];
         quo_in  = dividend[WIN_BITS-1] ? WIN_BITS'(-dividend) : WIN_BITS'(dividend);
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_BITS'(trial - {1'b0, den_ff}) : CNT_BITS'(trial);
         quo_in  = {quo_ff[WIN_BITS-2:0], fits};
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(WIN_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = OUT_BITS'(neg_ff ? -quo_ff : quo_ff);

endmodule

>>> src/bfe_datapath.sv
// Datapath of the 3x3 box filter: row stores, raster counters, column window,
// neighbour count and the result register. Depends on bfe_pkg and bfe_divider.
module bfe_datapath import bfe_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [PIXEL_BITS-1:0] req_pixel,
   input  logic                         req_flush,
   input  logic                         csr_write,
   input  logic [CSR_BITS-1:0]          csr_row_width,
   output logic signed [PIXEL_BITS-1:0] rsp_mean_value,
   output logic                         rsp_frame_end,
   output logic                         rsp_run_last
);

   localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_BITS    = (COL_BITS + 1 > CSR_BITS) ? COL_BITS + 1 : CSR_BITS;
   localparam int COLSUM_BITS = PIXEL_BITS + 2;
   localparam int WIN_BITS    = PIXEL_BITS + 4;

   // Raster control state.
   logic [COL_BITS-1:0] last_col_ff, last_col_in;
   logic [COL_BITS-1:0] column_ff, column_in;
   logic [1:0]          rows_ff, rows_in;
   logic [1:0]          rot_ff, rot_in;
   logic                pad_row_ff, pad_row_in;

   // Item held while its results are worked out.
   logic                         mid_ff, last_ff, pad_item_ff;
   logic                         above_ok_ff;
   logic [1:0]                   rot_item_ff;
   logic [COL_BITS-1:0]          col_item_ff;
   logic signed [PIXEL_BITS-1:0] pix_ff;

   // Row stores with registered reads.
   logic signed [PIXEL_BITS-1:0] store_a_ff [MAX_WIDTH];
   logic signed [PIXEL_BITS-1:0] store_b_ff [MAX_WIDTH];
   logic signed [PIXEL_BITS-1:0] store_c_ff [MAX_WIDTH];
   logic signed [PIXEL_BITS-1:0] rd_a_ff, rd_b_ff, rd_c_ff;

   // Column sums for columns c-2, c-1 and c.
   logic signed [COLSUM_BITS-1:0] col_m2_ff, col_m1_ff, col_m0_ff;

   logic signed [PIXEL_BITS-1:0] mean_ff;
   logic                         frame_end_ff, run_last_ff;

   logic [CMP_BITS-1:0]           csr_ext;
   logic                          col_zero, skip, pad_now, at_last;
   logic [COL_BITS-1:0]           col_cur;
   logic signed [PIXEL_BITS-1:0]  wr_data;
   logic signed [PIXEL_BITS-1:0]  above_px, prev_px;
   logic signed [COLSUM_BITS-1:0] colsum;
   logic [1:0]                    nrows, ncols;
   logic                          col_ge1, col_ge2;
   logic signed [WIN_BITS-1:0]    win_sum;
   logic [CNT_BITS-1:0]           count;
   logic signed [PIXEL_BITS-1:0]  quotient;
   logic                          div_busy;

   function automatic logic signed [PIXEL_BITS-1:0] store_pick(
      input logic signed [PIXEL_BITS-1:0] a,
      input logic signed [PIXEL_BITS-1:0] b,
      input logic signed [PIXEL_BITS-1:0] c,
      input logic [1:0]                   idx
   );
      logic signed [PIXEL_BITS-1:0] r;
      case (idx)
         2'd0:    r = a;
         2'd1:    r = b;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] rot_add(input logic [1:0] r, input logic [1:0] k);
      logic [2:0] s;
      s = {1'b0, r} + {1'b0, k};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   // Register write: zero acts as one pixel, anything past the stores as full width.
   always_comb begin
      csr_ext = CMP_BITS'(csr_row_width);
      if (csr_ext == '0) begin
         last_col_in = '0;
      end else if (csr_ext > CMP_BITS'(MAX_WIDTH)) begin
         last_col_in = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         last_col_in = COL_BITS'(csr_ext - CMP_BITS'(1));
      end
   end

   // Raster position and row kind of the item on offer.
   always_comb begin
      col_zero = column_ff == '0;
      skip     = col_zero && req_flush && (rows_ff == 2'd0);
      pad_now  = col_zero ? req_flush : pad_row_ff;
      col_cur  = (column_ff > last_col_ff) ? last_col_ff : column_ff;
      at_last  = col_cur == last_col_ff;
      wr_data  = req_flush ? '0 : req_pixel;

      column_in  = column_ff;
      rows_in    = rows_ff;
      rot_in     = rot_ff;
      pad_row_in = pad_row_ff;
      if (cmd.accept && !skip) begin
         if (at_last) begin
            column_in = '0;
            if (pad_now) begin
               rows_in    = 2'd0;
               rot_in     = 2'd0;
               pad_row_in = 1'b0;
            end else begin
               rows_in    = (rows_ff == 2'd2) ? 2'd2 : rows_ff + 2'd1;
               rot_in     = rot_add(rot_ff, 2'd1);
               pad_row_in = 1'b0;
            end
         end else begin
            column_in  = col_cur + COL_BITS'(1);
            pad_row_in = pad_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_BITS'(MAX_WIDTH - 1);
         column_ff   <= '0;
         rows_ff     <= 2'd0;
         rot_ff      <= 2'd0;
         pad_row_ff  <= 1'b0;
         mid_ff      <= 1'b0;
         last_ff     <= 1'b0;
         pad_item_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            last_col_ff <= last_col_in;
         end
         column_ff  <= column_in;
         rows_ff    <= rows_in;
         rot_ff     <= rot_in;
         pad_row_ff <= pad_row_in;
         if (cmd.accept) begin
            mid_ff      <= (rows_ff != 2'd0) && (col_cur != '0);
            last_ff     <= (rows_ff != 2'd0) && at_last;
            pad_item_ff <= pad_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         above_ok_ff <= rows_ff == 2'd2;
         rot_item_ff <= rot_ff;
         col_item_ff <= col_cur;
         pix_ff      <= wr_data;
      end
   end

   // The incoming row goes to the store that rotation points at.
   always_ff @(posedge clock) begin
      if (cmd.accept && !skip && !pad_now && rot_ff == 2'd0) begin
         store_a_ff[col_cur] <= wr_data;
      end
      if (cmd.accept) begin
         rd_a_ff <= store_a_ff[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !skip && !pad_now && rot_ff == 2'd1) begin
         store_b_ff[col_cur] <= wr_data;
      end
      if (cmd.accept) begin
         rd_b_ff <= store_b_ff[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !skip && !pad_now && rot_ff == 2'd2) begin
         store_c_ff[col_cur] <= wr_data;
      end
      if (cmd.accept) begin
         rd_c_ff <= store_c_ff[col_cur];
      end
   end

   // Column sum of the new column; rows above and below are left out at the edges.
   always_comb begin
      above_px = store_pick(rd_a_ff, rd_b_ff, rd_c_ff, rot_add(rot_item_ff, 2'd1));
      prev_px  = store_pick(rd_a_ff, rd_b_ff, rd_c_ff, rot_add(rot_item_ff, 2'd2));
      colsum   = (above_ok_ff ? COLSUM_BITS'(above_px) : '0)
               + COLSUM_BITS'(prev_px)
               + (pad_item_ff ? '0 : COLSUM_BITS'(pix_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         col_m2_ff <= col_m1_ff;
         col_m1_ff <= col_m0_ff;
         col_m0_ff <= colsum;
      end
   end

   // Window sum and neighbour count for the selected result.
   always_comb begin
      col_ge1 = col_item_ff != '0;
      col_ge2 = col_ge1 && (col_item_ff != COL_BITS'(1));
      nrows   = 2'd1 + {1'b0, above_ok_ff} + {1'b0, !pad_item_ff};
      if (cmd.sel_last) begin
         ncols   = col_ge1 ? 2'd2 : 2'd1;
         win_sum = (col_ge1 ? WIN_BITS'(col_m1_ff) : '0) + WIN_BITS'(col_m0_ff);
      end else begin
         ncols   = col_ge2 ? 2'd3 : 2'd2;
         win_sum = (col_ge2 ? WIN_BITS'(col_m2_ff) : '0) + WIN_BITS'(col_m1_ff)
                 + WIN_BITS'(col_m0_ff);
      end
      count = CNT_BITS'(nrows) * CNT_BITS'(ncols);
   end

   bfe_divider #(
      .WIN_BITS (WIN_BITS),
      .OUT_BITS (PIXEL_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (win_sum),
      .divisor  (count),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         mean_ff      <= quotient;
         frame_end_ff <= cmd.frame_end;
         run_last_ff  <= cmd.run_last;
      end
   end

   assign status.gives_mid  = mid_ff;
   assign status.gives_last = last_ff;
   assign status.pad_item   = pad_item_ff;
   assign status.div_busy   = div_busy;

   assign rsp_mean_value = mean_ff;
   assign rsp_frame_end  = frame_end_ff;
   assign rsp_run_last   = run_last_ff;

endmodule

>>> src/bfe_ctrl.sv
// Controller of the 3x3 box filter: sequences one item through column fold,
// window sum, division and result hand-off. Depends on bfe_pkg.
module bfe_ctrl import bfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      sel_last_ff, sel_last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COLUMN;
            end
         end
         ST_COLUMN: begin
            state_in = (status.gives_mid || status.gives_last) ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = (sel_last_ff || !status.gives_last) ? ST_IDLE : ST_SUM;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.sel_last  = sel_last_ff;
      cmd.frame_end = sel_last_ff && status.pad_item;
      cmd.run_last  = sel_last_ff || !status.gives_last;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_COLUMN: begin
            cmd.shift = 1'b1;
         end
         ST_SUM: begin
            cmd.load = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sel_last_in = sel_last_ff;
      if (state_ff == ST_COLUMN) begin
         sel_last_in = !status.gives_mid;
      end else if (cmd.emit) begin
         sel_last_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_last_ff  <= sel_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/box_filter_3x3_edge_normalized.sv
// Top level of the edge-normalised 3x3 box filter.
// Depends on bfe_pkg, the channel interfaces in bfe_if, bfe_ctrl and bfe_datapath.
//
//   Channel   Direction  Handshake      Carries
//   req_ch    in         valid/ready    pixel, flush
//   rsp_ch    out        valid/ready    mean_value, frame_end, run_last
//   csr_ch    in         valid/ready    row_width (always ready)
//
// An item that yields no result only folds its column into the window; each result
// it yields then takes a window sum, a pass through the bit-serial divider, one
// quotient bit per cycle, and a load of the output register.
// Reset is synchronous and active high; it clears the raster counters and the
// controller, while the row stores keep whatever they hold.
// A stalled result sits in the output register while the next item is accepted;
// only a second result meeting a still-full output register waits.
//
// Pixels arrive in raster order. The result for column c-1 of the previous row
// comes out when column c of the current row arrives, and the last item of a
// row also gives the result for the last column. A row of flush items after
// the last image row supplies the bottom edge and closes the frame, and the
// final result of that row carries frame_end. The neighbourhood sum is divided
// by the number of in-image neighbours, truncating toward zero.
// The row width register must only be written while the block is idle.
module box_filter_3x3_edge_normalized import bfe_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic         clock,
   input  logic         reset,
   bfe_req_if.sink      req_ch,
   bfe_rsp_if.source    rsp_ch,
   bfe_csr_if.sink      csr_ch
);

   cmd_type    cmd;
   status_type status;

   // The register is written whenever valid is high, so the port never stalls.
   assign csr_ch.ready = 1'b1;

   bfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   bfe_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_pixel      (req_ch.pixel),
      .req_flush      (req_ch.flush),
      .csr_write      (csr_ch.valid),
      .csr_row_width  (csr_ch.row_width),
      .rsp_mean_value (rsp_ch.mean_value),
      .rsp_frame_end  (rsp_ch.frame_end),
      .rsp_run_last   (rsp_ch.run_last)
   );

endmodule

>>> src/bfe_checker.sv
// Port-level checks for the 3x3 box filter, bound to the top level.
// Depends on bfe_pkg and on box_filter_3x3_edge_normalized.
module bfe_checker import bfe_pkg::*; #(
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [PIXEL_BITS-1:0] rsp_mean_value,
   input logic                         rsp_frame_end,
   input logic                         rsp_run_last
);

   // A held result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_value)
         && $stable(rsp_frame_end) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The frame's final result is also the last one of its item.
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame end without run last");

   // One item at a time: the input closes right after an item is taken,
   // and no result can be ready that early.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("input open or result early after an item");

endmodule

bind box_filter_3x3_edge_normalized bfe_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_mean_value (rsp_ch.mean_value),
   .rsp_frame_end  (rsp_ch.frame_end),
   .rsp_run_last   (rsp_ch.run_last)
);
